// ===== hw/rtl/humidity_sensor_frame_decoder_top_macros.svh =====
// assertion macros shared by the decoder modules
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_TOP_MACROS_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define HSFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hsfd assertion failed");
`define HSFD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hsfd forbidden condition seen");
`else
`define HSFD_ASSERT(lbl, clk, rst_n, prop)
`define HSFD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/hsfd_pkg.sv =====
`timescale 1ns / 1ps

package hsfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [2:0] POS_FIRST_HI   = 3'd0;
  localparam logic [2:0] POS_FIRST_LO   = 3'd1;
  localparam logic [2:0] POS_FIRST_CRC  = 3'd2;
  localparam logic [2:0] POS_SECOND_HI  = 3'd3;
  localparam logic [2:0] POS_SECOND_LO  = 3'd4;
  localparam logic [2:0] POS_SECOND_CRC = 3'd5;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_FIRST_BAD  = 2'd1;
  localparam logic [1:0] STAT_SECOND_BAD = 2'd2;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  localparam int TPROD_W = 31;
  localparam int HPROD_W = 30;

  typedef struct packed {
    logic        is_status;
    logic [1:0]  check_status;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } hsfd_frame_t;

  // msb first, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/hsfd_front.sv =====
`timescale 1ns / 1ps
`include "humidity_sensor_frame_decoder_top_macros.svh"

module hsfd_front import hsfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        push_ready,
  output logic        push_valid,
  output hsfd_frame_t push_frame
);

  logic        kind_r;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] first_r, first_nxt;
  logic [15:0] second_r, second_nxt;
  logic        bad_r, bad_nxt;

  logic        accept;
  logic        resync;
  logic [2:0]  eff_pos;
  logic [7:0]  eff_crc;
  logic        eff_bad;
  logic [7:0]  crc_in;
  logic [7:0]  crc_upd;
  logic [15:0] word;
  logic        byte_bad;

  assign in_tready = push_ready;
  assign accept    = in_tvalid & push_ready;

  always_comb begin
    resync   = in_tuser || (pos_r > POS_SECOND_CRC) || (kind_r && (pos_r > POS_FIRST_CRC));
    eff_pos  = resync ? POS_FIRST_HI : pos_r;
    eff_crc  = resync ? CRC_INIT : crc_r;
    eff_bad  = resync ? 1'b0 : bad_r;
    crc_in   = ((eff_pos == POS_FIRST_HI) || (eff_pos == POS_SECOND_HI)) ? CRC_INIT : eff_crc;
    crc_upd  = crc8_byte(crc_in, in_tdata);
    word     = {hold_r, in_tdata};
    byte_bad = (eff_crc != in_tdata);

    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    hold_nxt   = hold_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    bad_nxt    = bad_r;
    push_valid = 1'b0;
    push_frame = '{is_status: 1'b0, check_status: STAT_OK,
                   first_word: first_r, second_word: second_r};

    if (accept) begin
      case (eff_pos)
        POS_FIRST_HI, POS_SECOND_HI: begin
          crc_nxt  = crc_upd;
          hold_nxt = in_tdata;
          bad_nxt  = eff_bad;
          pos_nxt  = eff_pos + 3'd1;
        end
        POS_FIRST_LO: begin
          crc_nxt   = crc_upd;
          first_nxt = word;
          bad_nxt   = eff_bad;
          pos_nxt   = POS_FIRST_CRC;
        end
        POS_SECOND_LO: begin
          crc_nxt    = crc_upd;
          second_nxt = word;
          bad_nxt    = eff_bad;
          pos_nxt    = POS_SECOND_CRC;
        end
        POS_FIRST_CRC: begin
          crc_nxt = CRC_INIT;
          if (!kind_r) begin
            bad_nxt = byte_bad;
            pos_nxt = POS_SECOND_HI;
          end else begin
            bad_nxt    = 1'b0;
            pos_nxt    = POS_FIRST_HI;
            push_valid = 1'b1;
            push_frame = '{is_status: 1'b1,
                           check_status: byte_bad ? STAT_FIRST_BAD : STAT_OK,
                           first_word: first_r, second_word: 16'd0};
          end
        end
        default: begin
          // second crc, end of measurement frame
          crc_nxt    = CRC_INIT;
          bad_nxt    = 1'b0;
          pos_nxt    = POS_FIRST_HI;
          push_valid = 1'b1;
          push_frame = '{is_status: 1'b0,
                         check_status: eff_bad ? STAT_FIRST_BAD :
                                       (byte_bad ? STAT_SECOND_BAD : STAT_OK),
                         first_word: first_r, second_word: second_r};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= 1'b0;
      pos_r    <= POS_FIRST_HI;
      crc_r    <= CRC_INIT;
      hold_r   <= 8'd0;
      first_r  <= 16'd0;
      second_r <= 16'd0;
      bad_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        kind_r <= cfg_wr_data;
      end
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      hold_r   <= hold_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      bad_r    <= bad_nxt;
    end
  end

  `HSFD_ASSERT(a_pos_in_range, clk, rst_n, pos_r <= POS_SECOND_CRC)
  `HSFD_ASSERT(a_push_at_crc, clk, rst_n,
    push_valid |-> ((eff_pos == POS_FIRST_CRC) || (eff_pos == POS_SECOND_CRC)))

endmodule

// ===== hw/rtl/hsfd_queue.sv =====
`timescale 1ns / 1ps
`include "humidity_sensor_frame_decoder_top_macros.svh"

module hsfd_queue import hsfd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  hsfd_frame_t push_frame,
  output logic        pop_valid,
  input  logic        pop_ready,
  output hsfd_frame_t pop_frame
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hsfd_frame_t      entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_frame  = entry_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_frame;
    end
  end

  `HSFD_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_FULL)
  `HSFD_ASSERT(a_ptr_gap, clk, rst_n,
    ((count_r == '0) || (count_r == CNT_FULL)) |-> (wr_ptr_r == rd_ptr_r))

endmodule

// ===== hw/rtl/hsfd_back.sv =====
`timescale 1ns / 1ps
`include "humidity_sensor_frame_decoder_top_macros.svh"

module hsfd_back import hsfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  hsfd_frame_t pop_frame,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata
);

  logic                 s1_valid_r;
  hsfd_frame_t          s1_frame_r;
  logic [TPROD_W-1:0]   tprod_r;
  logic [HPROD_W-1:0]   hprod_r;
  logic                 out_valid_r;
  logic [63:0]          out_data_r, out_data_nxt;

  logic                 s2_load;
  logic                 s1_load;
  logic [14:0]          t_quo;
  logic [16:0]          t_rem;
  logic [14:0]          t_val;
  logic [13:0]          h_quo;
  logic [16:0]          h_rem;
  logic [13:0]          h_val;
  logic signed [14:0]   temp_centi;
  logic [13:0]          hum_centi;

  assign s2_load   = s1_valid_r && (!out_valid_r || out_tready);
  assign pop_ready = !s1_valid_r || s2_load;
  assign s1_load   = pop_valid && pop_ready;

  // divide by 65535: quotient from the high half, one correction step
  always_comb begin
    t_quo = tprod_r[TPROD_W-1:16];
    t_rem = {1'b0, tprod_r[15:0]} + {2'b00, t_quo};
    t_val = t_quo + ((t_rem >= FULL_SCALE) ? 15'd1 : 15'd0);
    h_quo = hprod_r[HPROD_W-1:16];
    h_rem = {1'b0, hprod_r[15:0]} + {3'b000, h_quo};
    h_val = h_quo + ((h_rem >= FULL_SCALE) ? 14'd1 : 14'd0);
    if (s1_frame_r.is_status) begin
      temp_centi = '0;
      hum_centi  = '0;
    end else begin
      temp_centi = $signed(t_val - TEMP_OFFSET);
      hum_centi  = h_val;
    end
    out_data_nxt = {1'b0, hum_centi, temp_centi, s1_frame_r.second_word,
                    s1_frame_r.first_word, s1_frame_r.check_status};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_ready) begin
        s1_valid_r <= pop_valid;
      end
      if (s2_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_frame_r <= pop_frame;
      tprod_r    <= TPROD_W'(pop_frame.first_word) * TPROD_W'(TEMP_SCALE);
      hprod_r    <= HPROD_W'(pop_frame.second_word) * HPROD_W'(HUM_SCALE);
    end
    if (s2_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `HSFD_ASSERT(a_stage_kept, clk, rst_n,
    (s1_valid_r && out_valid_r && !out_tready) |=> s1_valid_r)
  `HSFD_ASSERT_NEVER(a_no_take_when_full, clk, rst_n,
    s1_load && s1_valid_r && !s2_load)

endmodule

// ===== hw/rtl/humidity_sensor_frame_decoder_top.sv =====
// Sensor frame decoder. Takes one received byte per item on the in_ channel
// (restart flag in in_tuser) and one item per clock while the frame queue has
// room; each CRC-8 (poly 0x31, init 0xFF) is checked in the cycle its byte
// arrives. The last byte of a frame (sixth for a measurement frame, third for
// a status frame, chosen by cfg_wr_data) queues one frame record; the record
// then passes a multiply stage and a divide-by-65535 stage; it is held in the
// queue, then the multiply stage register, then the output register on out_.
// Results flow at one per cycle while out_tready is high; with out_tready low
// the output register, the multiply stage and the queue of QUEUE_DEPTH frames
// (2 or more) fill before in_tready drops.
`timescale 1ns / 1ps

module humidity_sensor_frame_decoder_top import hsfd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,  // frame_kind
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // data_byte
  input  logic        in_tuser,     // restart
  output logic        out_tvalid,
  input  logic        out_tready,
  // check_status[1:0], first_word[17:2], second_word[33:18],
  // temperature_centi[48:34], humidity_centi[62:49], zero[63]
  output logic [63:0] out_tdata
);

  logic        push_valid, push_ready;
  hsfd_frame_t push_frame;
  logic        pop_valid, pop_ready;
  hsfd_frame_t pop_frame;

  hsfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_frame (push_frame)
  );

  hsfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_frame(push_frame),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_frame (pop_frame)
  );

  hsfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_frame (pop_frame),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
